// File: hdl/adk_pkg.sv
package adk_pkg;

  // Field and register widths.
  localparam int unsigned SPEED_W  = 24;
  localparam int unsigned STEER_W  = 18;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned WB_W     = 16;
  localparam int unsigned TRACK_W  = 17;
  localparam int unsigned RADIUS_W = 16;
  localparam int unsigned LIMIT_W  = 17;
  localparam int unsigned DB_W     = 16;
  localparam int unsigned CFG_W    = 17;

  // CORDIC sizing: x and y are Q32 magnitudes up to about 2^40.3, z is Q30.
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned ATAN_LEN      = 24;
  localparam int unsigned NSTG = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int unsigned XW   = 44;
  localparam int unsigned ZW   = 33;

  // Wheel divider: 42-bit dividend, 17-bit divisor, one quotient bit a stage.
  localparam int unsigned DIV_BITS = 42;
  localparam int unsigned DEN_W    = 17;
  localparam int unsigned NUM_W    = 43;

  // atan(2^-i) in Q30, truncated.
  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef enum logic [2:0] {
    CFG_WHEELBASE = 3'd0,
    CFG_TRACK     = 3'd1,
    CFG_RADIUS    = 3'd2,
    CFG_MAX_STEER = 3'd3,
    CFG_DEADBAND  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_ZERO   = 2'd0,
    SRC_CORDIC = 2'd1,
    SRC_LIMIT  = 2'd2
  } steer_src_e;

  typedef struct packed {
    logic signed [SPEED_W-1:0] linear_speed;
    logic signed [SPEED_W-1:0] angular_rate;
  } cmd_t;

  typedef struct packed {
    logic signed [STEER_W-1:0] steer_angle;
    logic signed [RATE_W-1:0]  left_wheel_rate;
    logic signed [RATE_W-1:0]  right_wheel_rate;
  } res_t;

  // Side data that travels alongside the wheel dividers.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    steer_src_e           src;
    logic                 yaw_pos;
    logic                 l_neg;
    logic                 l_zero;
    logic                 r_neg;
    logic                 r_zero;
  } side_t;

endpackage

// File: hdl/adk_wheel_div.sv
module adk_wheel_div
  import adk_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [DEN_W-1:0]    den_i,
  input  logic [DIV_BITS-1:0] dvd_i,
  output logic [DIV_BITS-1:0] quo_o
);

  logic [DEN_W-1:0]    rem_q [DIV_BITS+1];
  logic [DIV_BITS-1:0] dvd_q [DIV_BITS+1];
  logic [DIV_BITS-1:0] quo_q [DIV_BITS+1];

  // The dividend enters with a cleared remainder.
  always_comb begin
    rem_q[0] = '0;
    dvd_q[0] = dvd_i;
    quo_q[0] = '0;
  end

  // Restoring division, one quotient bit per stage, MSB first.
  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_step
    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] rem_sub;
    logic           ge;

    always_comb begin
      rem_sh  = {rem_q[k-1], dvd_q[k-1][DIV_BITS-1]};
      ge      = (rem_sh >= {1'b0, den_i});
      rem_sub = rem_sh - {1'b0, den_i};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        dvd_q[k] <= {dvd_q[k-1][DIV_BITS-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][DIV_BITS-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DIV_BITS];

endmodule

// File: hdl/ackermann_drive_kinematics.sv
// Ackermann drive kinematics. Each command word (signed speed and yaw rate)
// yields one result word: a front steering angle from a 16-stage vectoring
// CORDIC, and two rear wheel rates, each from a 42-step restoring divider.
// The pipeline takes one word every cycle unless stalled; each word passes the
// input registers, divider stages and output registers. A stall at a held output
// word freezes the pipeline and is passed back to the input in the same cycle.
// Configuration registers may be written only while the pipeline is empty.
module ackermann_drive_kinematics
  import adk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cmd_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output res_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [WB_W-1:0]     wheelbase_q;
  logic [TRACK_W-1:0]  track_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [LIMIT_W-1:0]  max_steer_q;
  logic [DB_W-1:0]     deadband_q;

  logic                en;
  logic                valid_q [DIV_BITS+1];
  side_t               side_q  [DIV_BITS+1];
  logic [DIV_BITS-1:0] mag_l_q, mag_r_q;
  logic [DIV_BITS-1:0] quo_l, quo_r;
  logic                out_valid_q;
  res_t                out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheelbase_q <= WB_W'(13107);
      track_q     <= TRACK_W'(10879);
      radius_q    <= RADIUS_W'(2294);
      max_steer_q <= LIMIT_W'(51446);
      deadband_q  <= DB_W'(328);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WHEELBASE: wheelbase_q <= cfg_data_i[WB_W-1:0];
        CFG_TRACK:     track_q     <= cfg_data_i[TRACK_W-1:0];
        CFG_RADIUS:    radius_q    <= cfg_data_i[RADIUS_W-1:0];
        CFG_MAX_STEER: max_steer_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_DEADBAND:  deadband_q  <= cfg_data_i[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished word is held at the output.
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Input stage: products, CORDIC start vector and wheel numerators.
  logic signed [SPEED_W:0]   v, w, av, aw, wf;
  logic signed [41:0]        y0, turn;
  logic signed [NUM_W-1:0]   base, num_l, num_r;
  logic [NUM_W-1:0]          abs_l, abs_r;
  side_t                     side_in;

  always_comb begin
    v     = SPEED_W'(0) + {in_data_i.linear_speed[SPEED_W-1], in_data_i.linear_speed};
    w     = {in_data_i.angular_rate[SPEED_W-1], in_data_i.angular_rate};
    av    = v[SPEED_W] ? -v : v;
    aw    = w[SPEED_W] ? -w : w;
    wf    = v[SPEED_W] ? -w : w;
    y0    = $signed({1'b0, wheelbase_q}) * wf;
    turn  = w * $signed({1'b0, track_q});
    base  = NUM_W'(v) <<< 17;
    num_l = base - NUM_W'(turn);
    num_r = base + NUM_W'(turn);
    abs_l = num_l[NUM_W-1] ? NUM_W'(-num_l) : NUM_W'(num_l);
    abs_r = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);

    side_in.x       = XW'(av) <<< 16;
    side_in.y       = XW'(y0);
    side_in.z       = '0;
    side_in.yaw_pos = !w[SPEED_W] && (w != '0);
    side_in.l_neg   = num_l[NUM_W-1];
    side_in.l_zero  = (num_l == '0);
    side_in.r_neg   = num_r[NUM_W-1];
    side_in.r_zero  = (num_r == '0);
    if (av > $signed({9'b0, deadband_q})) begin
      side_in.src = SRC_CORDIC;
    end else if (aw > $signed({9'b0, deadband_q})) begin
      side_in.src = SRC_LIMIT;
    end else begin
      side_in.src = SRC_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      mag_l_q   <= DIV_BITS'(abs_l + NUM_W'(radius_q));
      mag_r_q   <= DIV_BITS'(abs_r + NUM_W'(radius_q));
    end
  end

  // Wheel dividers: (|num| + radius) / (2 * radius).
  adk_wheel_div u_div_l (
    .clk_i (clk_i),
    .en_i  (en),
    .den_i ({radius_q, 1'b0}),
    .dvd_i (mag_l_q),
    .quo_o (quo_l)
  );

  adk_wheel_div u_div_r (
    .clk_i (clk_i),
    .en_i  (en),
    .den_i ({radius_q, 1'b0}),
    .dvd_i (mag_r_q),
    .quo_o (quo_r)
  );

  // CORDIC rotations in the first stages; later stages only carry the data.
  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_stage
    side_t nxt;

    if (k <= NSTG) begin : g_rot
      logic signed [XW-1:0] xs, ys;
      logic signed [ZW-1:0] ang;
      always_comb begin
        nxt = side_q[k-1];
        xs  = side_q[k-1].x >>> (k - 1);
        ys  = side_q[k-1].y >>> (k - 1);
        ang = $signed({1'b0, ATAN_Q30[k-1]});
        if (side_q[k-1].y > 0) begin
          nxt.x = side_q[k-1].x + ys;
          nxt.y = side_q[k-1].y - xs;
          nxt.z = side_q[k-1].z + ang;
        end else begin
          nxt.x = side_q[k-1].x - ys;
          nxt.y = side_q[k-1].y + xs;
          nxt.z = side_q[k-1].z - ang;
        end
      end
    end else begin : g_pass
      always_comb nxt = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= nxt;
      end
    end
  end

  // Output stage: round and clamp the angle, saturate the wheel rates.
  side_t                     fin;
  logic signed [ZW-1:0]      z_rnd;
  logic signed [19:0]        steer, lim;
  res_t                      res_d;

  always_comb begin
    fin   = side_q[DIV_BITS];
    z_rnd = (fin.z + ZW'(8192)) >>> 14;
    lim   = $signed({3'b0, max_steer_q});
    case (fin.src)
      SRC_CORDIC: steer = 20'(z_rnd);
      SRC_LIMIT:  steer = fin.yaw_pos ? lim : -lim;
      default:    steer = '0;
    endcase
    if (steer > lim) begin
      steer = lim;
    end
    if (steer < -lim) begin
      steer = -lim;
    end
    res_d.steer_angle = steer[STEER_W-1:0];

    if (radius_q == '0) begin
      res_d.left_wheel_rate = fin.l_neg ? 32'sh8000_0000 :
                              (fin.l_zero ? '0 : 32'sh7FFF_FFFF);
    end else if (fin.l_neg) begin
      res_d.left_wheel_rate = (quo_l > DIV_BITS'(33'h1_0000_0000 >> 1)) ?
                              32'sh8000_0000 : -$signed(quo_l[RATE_W-1:0]);
    end else begin
      res_d.left_wheel_rate = (quo_l > DIV_BITS'(32'h7FFF_FFFF)) ?
                              32'sh7FFF_FFFF : $signed(quo_l[RATE_W-1:0]);
    end

    if (radius_q == '0) begin
      res_d.right_wheel_rate = fin.r_neg ? 32'sh8000_0000 :
                               (fin.r_zero ? '0 : 32'sh7FFF_FFFF);
    end else if (fin.r_neg) begin
      res_d.right_wheel_rate = (quo_r > DIV_BITS'(33'h1_0000_0000 >> 1)) ?
                               32'sh8000_0000 : -$signed(quo_r[RATE_W-1:0]);
    end else begin
      res_d.right_wheel_rate = (quo_r > DIV_BITS'(32'h7FFF_FFFF)) ?
                               32'sh7FFF_FFFF : $signed(quo_r[RATE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_q[DIV_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/tb_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the kinematics block, predicts each result word
// from the accepted command word and the current registers, and compares.
module tb_checker
  import adk_pkg::*;
(
  input  logic             clk_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  cmd_t             in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  res_t             out_data_i,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               fail_cnt_o,
  output int               pending_o
);

  localparam longint RATE_MAX = 64'sd2147483647;
  localparam longint RATE_MIN = -64'sd2147483648;

  logic [63:0] wheelbase_q   = 64'd13107;
  logic [63:0] track_q       = 64'd10879;
  logic [63:0] radius_q      = 64'd2294;
  logic [63:0] max_steer_q   = 64'd51446;
  logic [63:0] deadband_q    = 64'd328;

  res_t kin_expected_q[$];
  int   fail_cnt = 0;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = kin_expected_q.size();

  // Vectoring CORDIC for atan(wheelbase*yaw/speed), angle rounded to Q16.
  function automatic longint steer_angle(longint v, longint w);
    longint x, y, z, xs, ys;
    int     n;
    x = (v < 0 ? -v : v) * 65536;
    y = longint'(wheelbase_q) * w;
    z = 0;
    n = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    if (v < 0) y = -y;
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_Q30[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_Q30[i]);
      end
    end
    return (z + 8192) >>> 14;
  endfunction

  // Rounded, saturated division of a doubled numerator by twice the radius.
  function automatic longint wheel_speed(longint num);
    logic [63:0] den, mag, q;
    den = 2 * radius_q;
    if (den == 0) return num > 0 ? RATE_MAX : (num < 0 ? RATE_MIN : 0);
    mag = num < 0 ? -num : num;
    q = (mag + radius_q) / den;
    if (num < 0) return q > 64'd2147483648 ? RATE_MIN : -longint'(q);
    return q > 64'd2147483647 ? RATE_MAX : longint'(q);
  endfunction

  function automatic res_t predict_kinematics(cmd_t c);
    res_t   r;
    longint v, w, lim, steer, base, turn;
    v = c.linear_speed;
    w = c.angular_rate;
    lim = longint'(max_steer_q);
    steer = 0;
    base = v * 131072;
    turn = w * longint'(track_q);
    if ((v < 0 ? -v : v) > longint'(deadband_q)) steer = steer_angle(v, w);
    else if ((w < 0 ? -w : w) > longint'(deadband_q)) steer = w > 0 ? lim : -lim;
    if (steer > lim) steer = lim;
    if (steer < -lim) steer = -lim;
    r.steer_angle      = steer[STEER_W-1:0];
    r.left_wheel_rate  = RATE_W'(wheel_speed(base - turn));
    r.right_wheel_rate = RATE_W'(wheel_speed(base + turn));
    return r;
  endfunction

  always @(posedge clk_i) begin
    res_t exp_r;
    // Register writes mirror the block's masking.
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WHEELBASE: wheelbase_q = cfg_data_i[WB_W-1:0];
        CFG_TRACK:     track_q     = cfg_data_i[TRACK_W-1:0];
        CFG_RADIUS:    radius_q    = cfg_data_i[RADIUS_W-1:0];
        CFG_MAX_STEER: max_steer_q = cfg_data_i[LIMIT_W-1:0];
        CFG_DEADBAND:  deadband_q  = cfg_data_i[DB_W-1:0];
        default: ;
      endcase
    end
    if (in_valid_i && !in_stall_i) kin_expected_q.push_back(predict_kinematics(in_data_i));
    // Compare each delivered word with the oldest prediction.
    if (out_valid_i && !out_stall_i) begin
      if (kin_expected_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data_i);
        fail_cnt++;
      end else begin
        exp_r = kin_expected_q.pop_front();
        if (exp_r.steer_angle !== out_data_i.steer_angle) begin
          $display("%0t: steering expected %0d actual %0d", $time,
                   exp_r.steer_angle, out_data_i.steer_angle);
          fail_cnt++;
        end
        if (exp_r.left_wheel_rate !== out_data_i.left_wheel_rate) begin
          $display("%0t: left rate expected %0d actual %0d", $time,
                   exp_r.left_wheel_rate, out_data_i.left_wheel_rate);
          fail_cnt++;
        end
        if (exp_r.right_wheel_rate !== out_data_i.right_wheel_rate) begin
          $display("%0t: right rate expected %0d actual %0d", $time,
                   exp_r.right_wheel_rate, out_data_i.right_wheel_rate);
          fail_cnt++;
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import adk_pkg::*;
();

  localparam int LATENCY = 44;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  cmd_t             in_data;
  logic             out_valid;
  logic             out_stall;
  res_t             out_data;
  logic             cfg_we;
  logic [2:0]       cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  int               fail_cnt;
  int               pending;
  bit               hold_long;
  bit               sink_quiet;

  ackermann_drive_kinematics i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  tb_checker i_checker (
    .clk_i      (clk),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
  endfunction

  // Receiver stall, with a long hold-off when requested.
  initial begin
    int g;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (120) @(negedge clk);
        hold_long = 1'b0;
        out_stall <= 1'b0;
      end else if (sink_quiet) begin
        out_stall <= 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_stall <= 1'b1;
          repeat (g) @(negedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  end

  task automatic send_cmd(input logic [23:0] v, input logic [23:0] w, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.linear_speed <= v;
    in_data.angular_rate <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  // Random speed/yaw with emphasis on small values, deadband edges and extremes.
  function automatic logic [23:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 700) - 350);
      1: return 24'($urandom);
      2: return $urandom_range(0, 1) ? 24'(24'h7FFFFF - $urandom_range(0, 3))
                                     : 24'(24'h800000 + $urandom_range(0, 3));
      3: return 24'($urandom_range(0, 2) - 1);
      default: return 24'($urandom_range(0, 262143) - 131072);
    endcase
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) send_cmd(rand_field(), rand_field(), 1'b1);
  endtask

  initial begin
    logic [23:0] edge_vals[8];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_WHEELBASE;
    cfg_data = '0;
    hold_long = 1'b0;
    sink_quiet = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed words under reset settings: extremes, deadband edges, zero yaw,
    // reversing, pure rotation.
    edge_vals = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'd328, 24'd329,
                  -24'sd329, 24'hFFFFFF, 24'd65536};
    for (int i = 0; i < 8; i++) send_cmd(edge_vals[i], edge_vals[7 - i], 1'b0);
    send_cmd(24'd65536, 24'd0, 1'b0);
    send_cmd(-24'sd65536, 24'd30000, 1'b0);
    send_cmd(24'd0, 24'd500, 1'b0);
    send_cmd(24'd0, -24'sd500, 1'b0);
    send_cmd(24'd10, 24'd328, 1'b0);
    send_cmd(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_cmd(24'h800000, 24'h800000, 1'b0);
    drain_pipe();

    // Zero radius, largest track, zero deadband, large limit above range.
    write_reg(CFG_RADIUS, 17'd0);
    write_reg(CFG_TRACK, 17'h1FFFF);
    write_reg(CFG_DEADBAND, 17'd0);
    write_reg(CFG_MAX_STEER, 17'h1FFFF);
    write_reg(CFG_WHEELBASE, 17'h1FFFF);
    write_reg(cfg_idx_e'(3'd6), 17'h12345);
    send_cmd(24'd0, 24'd0, 1'b0);
    send_cmd(24'd5, -24'sd7, 1'b0);
    send_cmd(24'h800000, 24'h7FFFFF, 1'b0);
    random_phase(200);
    drain_pipe();

    // Long receiver hold-off with the sender still offering words.
    write_reg(CFG_RADIUS, 17'd1);
    write_reg(CFG_TRACK, 17'd0);
    write_reg(CFG_MAX_STEER, 17'd0);
    write_reg(CFG_DEADBAND, 17'hFFFF);
    write_reg(CFG_WHEELBASE, 17'd1);
    hold_long = 1'b1;
    for (int i = 0; i < 100; i++) send_cmd(rand_field(), rand_field(), 1'b0);
    random_phase(200);
    drain_pipe();

    // Reset-like settings with mid values, and a sink that never stalls.
    write_reg(CFG_RADIUS, 17'd2294);
    write_reg(CFG_TRACK, 17'd10879);
    write_reg(CFG_MAX_STEER, 17'd102943);
    write_reg(CFG_DEADBAND, 17'd328);
    write_reg(CFG_WHEELBASE, 17'd13107);
    sink_quiet = 1'b1;
    for (int i = 0; i < 200; i++) send_cmd(rand_field(), rand_field(), 1'b0);
    sink_quiet = 1'b0;
    random_phase(200);
    drain_pipe();

    // Random register settings.
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_WHEELBASE, CFG_W'($urandom_range(1, 65535)));
      write_reg(CFG_TRACK, CFG_W'($urandom_range(0, 131071)));
      write_reg(CFG_RADIUS, CFG_W'($urandom_range(1, 65535)));
      write_reg(CFG_MAX_STEER, CFG_W'($urandom_range(0, 102943)));
      write_reg(CFG_DEADBAND, CFG_W'($urandom_range(0, 2000)));
      random_phase(200);
      drain_pipe();
    end

    if (fail_cnt == 0) begin
      $display("ackermann_drive_kinematics test passed");
    end else begin
      $display("ackermann_drive_kinematics test failed");
    end
    $finish;
  end

  initial begin
    #(20 * 1000000);
    $display("ackermann_drive_kinematics test failed");
    $finish;
  end

endmodule

// File: ackermann_drive_kinematics.f
hdl/adk_pkg.sv
hdl/adk_wheel_div.sv
hdl/ackermann_drive_kinematics.sv
tb/tb_checker.sv
tb/tb_top.sv
